FILE: sv/acs_pkg.sv
// Shared types, constants and digit helpers for the seven-segment alarm clock.
package acs_pkg;

  localparam int RING_TICKS = 31;
  localparam int CD_W       = $clog2(RING_TICKS + 1);

  localparam int SEC_W  = 6;
  localparam int MIN_W  = 6;
  localparam int HR_W   = 5;
  localparam int KEY_W  = 4;
  localparam int SEG_W  = 7;

  localparam logic [SEC_W-1:0] SEC_WRAP   = SEC_W'(60);
  localparam logic [SEC_W-1:0] SEC_RING   = SEC_W'(2);
  localparam logic [MIN_W-1:0] MIN_LAST   = MIN_W'(59);
  localparam logic [HR_W-1:0]  HR_LAST    = HR_W'(23);
  localparam logic [MIN_W:0]   MIN_LIMIT  = (MIN_W + 1)'(60);
  localparam logic [HR_W:0]    HR_LIMIT   = (HR_W + 1)'(24);
  localparam logic [MIN_W-1:0] ALARM_MIN_RST = MIN_W'(7);
  localparam logic [HR_W-1:0]  ALARM_HR_RST  = HR_W'(2);

  localparam logic [SEG_W-1:0] SEG_FLASH = 7'b0000001;
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'b1111111;

  typedef enum logic [1:0] {
    MODE_RUN       = 2'd0,
    MODE_SET_TIME  = 2'd1,
    MODE_SET_ALARM = 2'd2,
    MODE_OFF       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SHOW_TIME  = 2'd0,
    SHOW_FLASH = 2'd1,
    SHOW_BLANK = 2'd2
  } disp_sel_t;

  typedef struct packed {
    disp_sel_t        sel;
    logic [MIN_W-1:0] mins;
    logic [HR_W-1:0]  hrs;
    logic             buzzer;
  } disp_t;

  // Tens digit of a value below 64.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    if (v >= 6'd10) t = 4'd1;
    if (v >= 6'd20) t = 4'd2;
    if (v >= 6'd30) t = 4'd3;
    if (v >= 6'd40) t = 4'd4;
    if (v >= 6'd50) t = 4'd5;
    if (v >= 6'd60) t = 4'd6;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t10;
    t10 = 6'(tens_of(v)) * 6'd10;
    return 4'(v - t10);
  endfunction

  // Active-low gfedcba pattern; anything above nine shows the flash bar.
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'b1000000;
      4'd1:    s = 7'b1111001;
      4'd2:    s = 7'b0100100;
      4'd3:    s = 7'b0110000;
      4'd4:    s = 7'b0011001;
      4'd5:    s = 7'b0010010;
      4'd6:    s = 7'b0000010;
      4'd7:    s = 7'b1111000;
      4'd8:    s = 7'b0000000;
      4'd9:    s = 7'b0010000;
      default: s = SEG_FLASH;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/acs_core.sv
// Time, alarm and ring countdown state with the per-tick update.
module acs_core import acs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  mode_t            mode,
  input  logic [KEY_W-1:0] minute_presses,
  input  logic [KEY_W-1:0] hour_presses,
  input  logic [KEY_W-1:0] reset_presses,
  output disp_t            disp
);

  logic [SEC_W-1:0] sec_r,   sec_nxt;
  logic [MIN_W-1:0] min_r,   min_nxt;
  logic [HR_W-1:0]  hr_r,    hr_nxt;
  logic [MIN_W-1:0] amin_r,  amin_nxt;
  logic [HR_W-1:0]  ahr_r,   ahr_nxt;
  logic [CD_W-1:0]  cd_r,    cd_nxt;

  logic             clr;
  logic [KEY_W-1:0] mp, hp;
  logic [MIN_W-1:0] min0, min1;
  logic [HR_W-1:0]  hr0, hr1;
  logic [CD_W-1:0]  cd0, cd1;
  logic [SEC_W-1:0] sec1;
  logic             wrap;
  logic [MIN_W:0]   msum;
  logic [HR_W:0]    hsum;

  always_comb begin
    clr  = (reset_presses != '0);
    mp   = clr ? '0 : minute_presses;
    hp   = clr ? '0 : hour_presses;
    min0 = clr ? '0 : min_r;
    hr0  = clr ? '0 : hr_r;
    cd0  = clr ? '0 : cd_r;

    sec_nxt  = sec_r;
    min_nxt  = min0;
    hr_nxt   = hr0;
    amin_nxt = amin_r;
    ahr_nxt  = ahr_r;
    cd_nxt   = '0;

    wrap = 1'b0;
    sec1 = '0;
    min1 = '0;
    hr1  = '0;
    cd1  = '0;
    msum = '0;
    hsum = '0;

    disp.sel    = SHOW_TIME;
    disp.mins   = min0;
    disp.hrs    = hr0;
    disp.buzzer = 1'b0;

    case (mode)
      MODE_RUN: begin
        // roll the minute at the sixtieth second, then the hour
        wrap = (sec_r >= SEC_WRAP);
        sec1 = wrap ? '0 : sec_r;
        min1 = min0;
        hr1  = hr0;
        if (wrap) begin
          if (min0 >= MIN_LAST) begin
            min1 = '0;
            hr1  = (hr0 >= HR_LAST) ? '0 : hr0 + HR_W'(1);
          end else begin
            min1 = min0 + MIN_W'(1);
          end
        end
        cd1 = cd0;
        if (hr1 == ahr_r && min1 == amin_r && sec1 <= SEC_RING)
          cd1 = CD_W'(RING_TICKS);
        disp.mins   = min1;
        disp.hrs    = hr1;
        disp.buzzer = cd1[0];
        disp.sel    = cd1[0] ? SHOW_FLASH : SHOW_TIME;
        cd_nxt  = (cd1 != '0) ? cd1 - CD_W'(1) : '0;
        if (mp != '0 || hp != '0)
          cd_nxt = '0;
        min_nxt = min1;
        hr_nxt  = hr1;
        sec_nxt = sec1 + SEC_W'(1);
      end
      MODE_SET_TIME: begin
        msum    = {1'b0, min0} + (MIN_W + 1)'(mp);
        hsum    = {1'b0, hr0} + (HR_W + 1)'(hp);
        min_nxt = (msum >= MIN_LIMIT) ? '0 : msum[MIN_W-1:0];
        hr_nxt  = (hsum >= HR_LIMIT) ? '0 : hsum[HR_W-1:0];
        disp.mins = min_nxt;
        disp.hrs  = hr_nxt;
      end
      MODE_SET_ALARM: begin
        msum     = {1'b0, amin_r} + (MIN_W + 1)'(mp);
        hsum     = {1'b0, ahr_r} + (HR_W + 1)'(hp);
        amin_nxt = (msum >= MIN_LIMIT) ? '0 : msum[MIN_W-1:0];
        ahr_nxt  = (hsum >= HR_LIMIT) ? '0 : hsum[HR_W-1:0];
        disp.mins = amin_nxt;
        disp.hrs  = ahr_nxt;
      end
      default: begin
        disp.sel = SHOW_BLANK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hr_r   <= '0;
      amin_r <= ALARM_MIN_RST;
      ahr_r  <= ALARM_HR_RST;
      cd_r   <= '0;
    end else if (fire) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hr_r   <= hr_nxt;
      amin_r <= amin_nxt;
      ahr_r  <= ahr_nxt;
      cd_r   <= cd_nxt;
    end
  end

endmodule

FILE: sv/acs_disp.sv
// Seven-segment encoding of the four digits for one tick, or the flash or blank pattern on all four.
module acs_disp import acs_pkg::*; (
  input  disp_t            disp,
  output logic [SEG_W-1:0] seg_minute_tens,
  output logic [SEG_W-1:0] seg_minute_ones,
  output logic [SEG_W-1:0] seg_hour_tens,
  output logic [SEG_W-1:0] seg_hour_ones,
  output logic             buzzer_on
);

  logic [5:0] hrs_ext;

  assign hrs_ext   = 6'(disp.hrs);
  assign buzzer_on = disp.buzzer;

  always_comb begin
    case (disp.sel)
      SHOW_TIME: begin
        seg_minute_tens = seg_of(tens_of(disp.mins));
        seg_minute_ones = seg_of(ones_of(disp.mins));
        seg_hour_tens   = seg_of(tens_of(hrs_ext));
        seg_hour_ones   = seg_of(ones_of(hrs_ext));
      end
      SHOW_FLASH: begin
        seg_minute_tens = SEG_FLASH;
        seg_minute_ones = SEG_FLASH;
        seg_hour_tens   = SEG_FLASH;
        seg_hour_ones   = SEG_FLASH;
      end
      default: begin
        seg_minute_tens = SEG_BLANK;
        seg_minute_ones = SEG_BLANK;
        seg_hour_tens   = SEG_BLANK;
        seg_hour_ones   = SEG_BLANK;
      end
    endcase
  end

endmodule

FILE: sv/alarm_clock_seven_segment.sv
// Top level of the seven-segment alarm clock: input stage, tick update, result stage.
//
// Usage:
//   in_*  : one word per one-second tick carrying the mode switches and the key
//           release counts gathered since the previous tick.
//   out_* : one word per tick with the four active-low gfedcba digit patterns
//           and the buzzer flag.
// Every accepted tick gives exactly one result word, in order.
// Tick path: the tick is captured in the input stage when accepted; the
//   clock state updates and the result register loads when the input stage
//   advances, which waits while the result register holds an undrained word.
// Throughput: one tick per cycle while out_tready is high; the tick update is a
//   single pass of narrow adds, compares and digit lookups between the two stages.
// Reset (rst_n low, synchronous): time 00:00, seconds 0, alarm 02:07, no ring
//   in progress, both stages empty.
// Stall: while out_tready is low the result word holds; the input stage still
//   takes one more tick, after which in_tready drops until the result drains.
module alarm_clock_seven_segment import acs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] mode, [5:2] minute_presses, [9:6] hour_presses,
  // [13:10] reset_presses, [15:14] zero
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] seg_minute_tens, [13:7] seg_minute_ones, [20:14] seg_hour_tens,
  // [27:21] seg_hour_ones, [28] buzzer_on, [31:29] zero
  output logic [31:0] out_tdata
);

  localparam int OUT_W = 4 * SEG_W + 1;

  // input stage
  logic             s1_vld_r, s1_vld_nxt;
  mode_t            s1_mode_r;
  logic [KEY_W-1:0] s1_mp_r, s1_hp_r, s1_rp_r;

  // result stage
  logic             out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             in_fire;
  logic             advance;
  disp_t            disp;
  logic [SEG_W-1:0] seg_mt, seg_mo, seg_ht, seg_ho;
  logic             buzz;

  // advance the input stage whenever the result register is free or draining
  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire)
      s1_vld_nxt = 1'b1;
    else if (advance)
      s1_vld_nxt = 1'b0;

    out_vld_nxt = out_vld_r;
    if (advance)
      out_vld_nxt = 1'b1;
    else if (out_tready)
      out_vld_nxt = 1'b0;

    out_data_nxt = {buzz, seg_ho, seg_ht, seg_mo, seg_mt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers: load on a handshake, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= mode_t'(in_tdata[1:0]);
      s1_mp_r   <= in_tdata[5:2];
      s1_hp_r   <= in_tdata[9:6];
      s1_rp_r   <= in_tdata[13:10];
    end
    if (advance)
      out_data_r <= out_data_nxt;
  end

  acs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (advance),
    .mode           (s1_mode_r),
    .minute_presses (s1_mp_r),
    .hour_presses   (s1_hp_r),
    .reset_presses  (s1_rp_r),
    .disp           (disp)
  );

  acs_disp u_disp (
    .disp            (disp),
    .seg_minute_tens (seg_mt),
    .seg_minute_ones (seg_mo),
    .seg_hour_tens   (seg_ht),
    .seg_hour_ones   (seg_ho),
    .buzzer_on       (buzz)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(32 - OUT_W)'(0), out_data_r};

`ifndef ASSERT_OFF
  // a sounding buzzer always comes with the flash bar on every digit
  a_buzz_flash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |->
      (out_tdata[6:0] == SEG_FLASH && out_tdata[13:7] == SEG_FLASH &&
       out_tdata[20:14] == SEG_FLASH && out_tdata[27:21] == SEG_FLASH))
    else $error("buzzer on without flash pattern");

  // an accepted word is held in the input stage at the next edge
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted word not captured");

  // a waiting tick is not dropped while the result is stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_tready) |=> (s1_vld_r && out_vld_r))
    else $error("tick lost under stall");
`endif

endmodule
